FILE: src/ctd_pkg.sv
// shared types, phase codes and character constants for the chunked decoder
// no dependencies; imported by ctd_step and chunked_transfer_decoder
package ctd_pkg;

    localparam int MAX_SIZE_LINE = 16;
    localparam int REM_W         = 60;
    localparam int LINE_W        = 5;
    localparam int PHASE_W       = 3;
    localparam int STATUS_W      = 2;

    // decoder phases
    localparam logic [PHASE_W-1:0] PH_SIZE_EMPTY  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SIZE_DIGITS = 3'd1;
    localparam logic [PHASE_W-1:0] PH_CR_EMPTY    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_CR_DIGITS   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DATA        = 3'd4;
    localparam logic [PHASE_W-1:0] PH_DONE        = 3'd5;
    localparam logic [PHASE_W-1:0] PH_ERROR       = 3'd6;

    // reported status
    localparam logic [STATUS_W-1:0] ST_BUSY  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERROR = 2'd2;

    // characters
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_F  = 8'h46;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_F  = 8'h66;
    localparam logic [4:0] HEX_NONE   = 5'd16;
    localparam logic [7:0] HEX_TEN    = 8'd10;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [REM_W-1:0]   remaining;
        logic [LINE_W-1:0]  line_len;
    } t_dec_state;

    typedef struct packed {
        logic [7:0]          payload_byte;
        logic                payload_valid;
        logic [STATUS_W-1:0] status;
    } t_result;

    // hex digit value, or HEX_NONE when the byte is not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        begin
            v = 8'd0;
            if (c >= CHAR_0 && c <= CHAR_9) begin
                v = c - CHAR_0;
            end else if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
                v = c - CHAR_UC_A + HEX_TEN;
            end else if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
                v = c - CHAR_LC_A + HEX_TEN;
            end else begin
                v = {3'd0, HEX_NONE};
            end
            return v[4:0];
        end
    endfunction

endpackage

FILE: src/ctd_step.sv
// per-word decode step: next decoder state and result from current state and byte
// depends on ctd_pkg
module ctd_step
    import ctd_pkg::*;
(
    input  t_dec_state i_cur,
    input  logic [7:0] i_byte,
    output t_dec_state o_next,
    output t_result    o_res
);

    logic [4:0]        hv;
    logic [LINE_W-1:0] line_next;
    logic              line_over;
    logic [REM_W-1:0]  rem_dec;

    assign hv        = hex_value(i_byte);
    assign line_next = i_cur.line_len + LINE_W'(1);
    assign line_over = line_next >= LINE_W'(MAX_SIZE_LINE);
    assign rem_dec   = i_cur.remaining - REM_W'(1);

    always_comb begin
        o_next                = i_cur;
        o_res.payload_byte    = 8'd0;
        o_res.payload_valid   = 1'b0;

        case (i_cur.phase)
            PH_SIZE_EMPTY, PH_SIZE_DIGITS: begin
                if (i_byte == CHAR_CR) begin
                    o_next.phase    = (i_cur.phase == PH_SIZE_EMPTY) ? PH_CR_EMPTY
                                                                     : PH_CR_DIGITS;
                    o_next.line_len = line_next;
                    if (line_over) begin
                        o_next.phase = PH_ERROR;
                    end
                end else if (!hv[4]) begin
                    o_next.remaining = {i_cur.remaining[REM_W-5:0], hv[3:0]};
                    o_next.phase     = PH_SIZE_DIGITS;
                    o_next.line_len  = line_next;
                    if (line_over) begin
                        o_next.phase = PH_ERROR;
                    end
                end else begin
                    o_next.phase = PH_ERROR;
                end
            end
            PH_CR_EMPTY: begin
                if (i_byte == CHAR_LF) begin
                    o_next.phase     = PH_SIZE_EMPTY;
                    o_next.remaining = '0;
                    o_next.line_len  = '0;
                end else begin
                    o_next.phase = PH_ERROR;
                end
            end
            PH_CR_DIGITS: begin
                if (i_byte == CHAR_LF) begin
                    o_next.line_len = '0;
                    o_next.phase    = (i_cur.remaining == '0) ? PH_DONE : PH_DATA;
                end else begin
                    o_next.phase = PH_ERROR;
                end
            end
            PH_DATA: begin
                o_res.payload_byte  = i_byte;
                o_res.payload_valid = 1'b1;
                o_next.remaining    = rem_dec;
                if (rem_dec == '0) begin
                    o_next.phase    = PH_SIZE_EMPTY;
                    o_next.line_len = '0;
                end
            end
            PH_DONE: begin
                o_next.phase = PH_DONE;
            end
            default: begin
                o_next.phase = PH_ERROR;
            end
        endcase

        if (o_next.phase == PH_ERROR) begin
            o_res.status = ST_ERROR;
        end else if (o_next.phase == PH_DONE) begin
            o_res.status = ST_DONE;
        end else begin
            o_res.status = ST_BUSY;
        end
    end

endmodule

FILE: src/chunked_transfer_decoder.sv
// chunked transfer decoder: input register, decoder state and result register
// depends on ctd_pkg and ctd_step
//
// usage
//   slave stream carries one body byte per word on s_axis_tdata
//   master stream returns exactly one result word per input word:
//     m_axis_tdata[7:0] payload byte (zero when not payload)
//     m_axis_tdata[9:8] status: 0 in progress, 1 final chunk seen, 2 malformed
//     m_axis_tuser      set when the byte was chunk payload
//   throughput is one word per cycle while m_axis_tready stays high; a word
//   taken into the input register is decoded into the result register once
//   that register is free, and its result then shows on the master side
//   the decode step is a single pass through ctd_step: hex decode, a 60-bit
//   shift or decrement and a zero compare, between the input and result regs
//   the decoder state only advances when a word moves into the result register
// reset
//   synchronous active-low reset empties both registers and returns the
//   decoder to the start of a size line with a zero count
// backpressure
//   while m_axis_tready is low the result word holds; one more input word
//   can still be taken into the input register, then s_axis_tready drops
//   done and error states are sticky until reset
module chunked_transfer_decoder
    import ctd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] body_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [9:8] status, rest zero
    output logic        m_axis_tuser    // [0] payload_valid
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // decoder state
    t_dec_state r_state;
    t_dec_state n_state;

    // result register
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;

    logic advance;
    logic out_free;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || advance;

    ctd_step u_step (
        .i_cur  (r_state),
        .i_byte (r_in_byte),
        .o_next (n_state),
        .o_res  (n_out)
    );

    // input register: refills when empty or when the held word moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // decoder state steps once per decoded word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase     <= PH_SIZE_EMPTY;
            r_state.remaining <= '0;
            r_state.line_len  <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.status, r_out.payload_byte};
    assign m_axis_tuser  = r_out.payload_valid;

    // payload is only reported while the stream is still in progress
    a_payload_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (r_out.status == ST_BUSY))
        else $error("payload reported with done or error status");

    // done is sticky
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_DONE) |=> (r_state.phase == PH_DONE))
        else $error("left done phase");

    // error is sticky
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_ERROR) |=> (r_state.phase == PH_ERROR))
        else $error("left error phase");

    // a size line never grows past the limit without raising error
    a_line_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase != PH_ERROR) |-> (r_state.line_len < LINE_W'(MAX_SIZE_LINE)))
        else $error("size line over limit without error");

    // chunk data phase always has bytes left to pass
    a_data_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_DATA) |-> (r_state.remaining != '0))
        else $error("data phase with zero count");

endmodule
